// ===== rtl/core/q4bd_pkg.sv =====
// q4bd_pkg: types and constants for the q4 block dequantizer
// no dependencies
package q4bd_pkg;

	localparam int unsigned GroupElems = 8;
	localparam int unsigned NumGroups  = 4;

	localparam logic [31:0] DefaultNan = 32'hFFC0_0000;
	localparam logic [7:0]  ExpAllOnes = 8'hFF;

	typedef struct packed {
		logic [15:0] scale_bits;
		logic [63:0] quants_low;
		logic [63:0] quants_high;
		logic        final_block;
	} in_item_t;

	typedef struct packed {
		logic [31:0] value_0;
		logic [31:0] value_1;
		logic [31:0] value_2;
		logic [31:0] value_3;
		logic [31:0] value_4;
		logic [31:0] value_5;
		logic [31:0] value_6;
		logic [31:0] value_7;
		logic [1:0]  group_index;
		logic        last_of_block;
		logic        last_of_tensor;
	} out_item_t;

	// decoded scale, shared by all lanes of a group
	typedef struct packed {
		logic        sign;
		logic        is_nan;
		logic        is_inf;
		logic [9:0]  nan_mant;
		logic [10:0] mant;     // normalized significand, bit 10 set unless zero
		logic [8:0]  exp_base; // biased exponent of the significand's msb
	} scale_t;

endpackage

// ===== rtl/core/q4bd_lane.sv =====
// q4bd_lane: one weight lane, three pipeline stages
// depends on q4bd_pkg
module q4bd_lane (
	input  logic              clk,
	input  logic              en_s1,
	input  logic              en_s2,
	input  logic              en_s3,
	input  q4bd_pkg::scale_t  scale,
	input  logic [3:0]        code,
	output logic [31:0]       value
);
	import q4bd_pkg::*;

	// stage 1: magnitude and sign of code - 8
	logic [3:0] qmag_s1;
	logic       qneg_s1;
	scale_t     sc_s1;
	// stage 2: product
	logic [13:0] prod_s2;
	logic        rsign_s2;
	scale_t      sc_s2;
	logic        qzero_s2;

	logic [3:0] mag_c;
	always_comb begin
		if (code[3]) mag_c = {1'b0, code[2:0]};
		else         mag_c = 4'd8 - code;
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			qmag_s1 <= mag_c;
			qneg_s1 <= ~code[3];
			sc_s1   <= scale;
		end
		if (en_s2) begin
			prod_s2  <= sc_s1.mant * {10'd0, qmag_s1};
			rsign_s2 <= sc_s1.sign ^ qneg_s1;
			qzero_s2 <= (qmag_s1 == 4'd0);
			sc_s2    <= sc_s1;
		end
	end

	// stage 3: normalize. mant msb at bit 10, so product msb is at bit 10..13
	logic [1:0]  extra;
	logic [22:0] frac;
	logic [8:0]  expo;
	logic [31:0] res;
	always_comb begin
		extra = 2'd0;
		if (prod_s2[13])      extra = 2'd3;
		else if (prod_s2[12]) extra = 2'd2;
		else if (prod_s2[11]) extra = 2'd1;
		frac = {prod_s2, 9'd0} << (2'd3 - extra);
		frac = {frac[21:0], 1'b0} >> 0;
		expo = sc_s2.exp_base + {7'd0, extra};
		// nan payload top bit lands on the quiet bit, which is forced to one
		if (sc_s2.is_nan)
			res = {sc_s2.sign, ExpAllOnes, 1'b1, sc_s2.nan_mant[8:0], 13'd0};
		else if (sc_s2.is_inf)
			res = qzero_s2 ? DefaultNan : {rsign_s2, ExpAllOnes, 23'd0};
		else if (prod_s2 == 14'd0)
			res = {rsign_s2, 31'd0};
		else
			res = {rsign_s2, expo[7:0], frac};
	end

	always_ff @(posedge clk) begin
		if (en_s3) value <= res;
	end

endmodule

// ===== rtl/core/q4_block_dequantizer_unit.sv =====
// q4_block_dequantizer_unit: q4 block to 32 single-precision weights, eight per item
// the first result item of a block passes the block holder, then lane stages s1, s2 and s3
// one result item per cycle unless the output stalls; a new block enters as the last group issues
// reset clears the sequencer and all pipeline valid bits; data registers are not reset
// depends on q4bd_pkg and q4bd_lane
module q4_block_dequantizer_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  q4bd_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output q4bd_pkg::out_item_t out_data
);
	import q4bd_pkg::*;

	// block holding register, groups are issued from it one per cycle while the output is not stalled
	in_item_t   blk_q;
	logic       blk_valid_q;
	logic [1:0] grp_q;
	scale_t     sc_q;

	// pipeline valid bits and side info
	logic       v_s1, v_s2, v_s3;
	logic [1:0] g_s1, g_s2, g_s3;
	logic       f_s1, f_s2, f_s3;

	// the whole pipe advances together unless the output is stalled
	logic adv;
	assign adv = ~(v_s3 & out_stall);

	logic issue, last_issue;
	assign issue      = blk_valid_q & adv;
	assign last_issue = issue & (grp_q == 2'd3);
	// take a new block when the holder is empty or being drained this cycle
	assign in_stall = blk_valid_q & ~last_issue;

	// scale decode: widen half to single, subnormals normalized
	scale_t sc_c;
	logic [4:0] hexp;
	logic [9:0] hmant;
	logic [3:0] lz;
	always_comb begin
		hexp  = in_data.scale_bits[14:10];
		hmant = in_data.scale_bits[9:0];
		lz    = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (hmant[i]) lz = 4'(9 - i);
		end
		sc_c.sign     = in_data.scale_bits[15];
		sc_c.is_nan   = (hexp == 5'h1F) & (hmant != 10'd0);
		sc_c.is_inf   = (hexp == 5'h1F) & (hmant == 10'd0);
		sc_c.nan_mant = hmant;
		if (hexp == 5'd0) begin
			// value m*2^-24, msb at 9-lz: exponent 127 - 24 + 9 - lz - 10 + 10
			sc_c.mant     = {hmant, 1'b0} << lz;
			sc_c.exp_base = 9'd112 - {5'd0, lz};
		end else begin
			sc_c.mant     = {1'b1, hmant};
			sc_c.exp_base = {4'd0, hexp} + 9'd112;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_valid_q <= 1'b0;
			grp_q       <= 2'd0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (in_valid & ~in_stall) begin
				blk_valid_q <= 1'b1;
			end else if (last_issue) begin
				blk_valid_q <= 1'b0;
			end
			if (issue) grp_q <= grp_q + 2'd1;
			if (adv) begin
				v_s1 <= issue;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid & ~in_stall) begin
			blk_q <= in_data;
			sc_q  <= sc_c;
		end
		if (adv) begin
			g_s1 <= grp_q;
			f_s1 <= blk_q.final_block;
			g_s2 <= g_s1;
			f_s2 <= f_s1;
			g_s3 <= g_s2;
			f_s3 <= f_s2;
		end
	end

	// nibbles of the current group
	logic [31:0] grp_codes;
	always_comb begin
		case (grp_q)
			2'd0:    grp_codes = blk_q.quants_low[31:0];
			2'd1:    grp_codes = blk_q.quants_low[63:32];
			2'd2:    grp_codes = blk_q.quants_high[31:0];
			default: grp_codes = blk_q.quants_high[63:32];
		endcase
	end

	logic [31:0] vals [GroupElems];
	for (genvar l = 0; l < GroupElems; l++) begin : g_lane
		q4bd_lane u_lane (
			.clk   (clk),
			.en_s1 (adv),
			.en_s2 (adv),
			.en_s3 (adv),
			.scale (sc_q),
			.code  (grp_codes[4*l +: 4]),
			.value (vals[l])
		);
	end

	assign out_valid = v_s3;
	always_comb begin
		out_data.value_0        = vals[0];
		out_data.value_1        = vals[1];
		out_data.value_2        = vals[2];
		out_data.value_3        = vals[3];
		out_data.value_4        = vals[4];
		out_data.value_5        = vals[5];
		out_data.value_6        = vals[6];
		out_data.value_7        = vals[7];
		out_data.group_index    = g_s3;
		out_data.last_of_block  = (g_s3 == 2'(NumGroups - 1));
		out_data.last_of_tensor = (g_s3 == 2'(NumGroups - 1)) & f_s3;
	end

endmodule
